// ===== design/rer_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient edge run extractor package
// Shared widths, limits, register indexes, state types and the record that
// travels from the run tracker to the strength unit.
// ----------------------------------------------------------------------------
package rer_pkg;

   localparam int MAX_LINE_LENGTH = 4096;
   localparam int POS_W           = 12;
   localparam int PIX_W           = 8;
   localparam int LINE_W          = 12;
   localparam int TOTAL_W         = 20;
   localparam int COUNT_W         = 13;
   localparam int LEN_W           = 13;
   localparam int GAP_W           = 12;
   localparam int STRENGTH_W      = 9;
   localparam int DIVISOR_W       = 20;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 13;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int DIV_STEPS       = 8;
   localparam int STEP_W          = $clog2(DIV_STEPS);

   localparam logic [POS_W-1:0]      POS_MAX       = POS_W'(MAX_LINE_LENGTH - 1);
   localparam logic [TOTAL_W-1:0]    TOTAL_MAX     = '1;
   localparam logic [COUNT_W-1:0]    COUNT_MAX     = '1;
   localparam logic [6:0]            GRAD_SCALE    = 7'd90;
   localparam logic [STRENGTH_W-1:0] STRENGTH_FULL = STRENGTH_W'(256);

   localparam logic [PIX_W-1:0]   RESET_THRESHOLD  = 8'd16;
   localparam logic [LEN_W-1:0]   RESET_MIN_LENGTH = 13'd24;
   localparam logic [GAP_W-1:0]   RESET_MAX_GAP    = 12'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_THRESHOLD  = 2'd0,
      CSR_MIN_LENGTH = 2'd1,
      CSR_MAX_GAP    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [PIX_W-1:0] threshold;
      logic [LEN_W-1:0] min_length;
      logic [GAP_W-1:0] max_gap;
   } cfg_type;

   typedef struct packed {
      logic [LINE_W-1:0]  line;
      logic [POS_W-1:0]   first;
      logic [POS_W-1:0]   last;
      logic [TOTAL_W-1:0] total;
      logic [COUNT_W-1:0] count;
   } run_rec_type;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_CHECK,
      ST_DIVIDE,
      ST_EMIT
   } back_state_type;

endpackage

// ===== design/rer_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run tracker
// Forms the gradient of each pixel pair, tracks the open run along the line
// and queues every closed run that is long enough.
// ----------------------------------------------------------------------------
module rer_front (
   input  logic                            clock,
   input  logic                            reset,
   input  rer_pkg::cfg_type                cfg,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [rer_pkg::PIX_W-1:0]       req_before_pixel,
   input  logic [rer_pkg::PIX_W-1:0]       req_after_pixel,
   input  logic [rer_pkg::LINE_W-1:0]      req_line_index,
   input  logic                            req_end_of_line,
   input  rer_pkg::queue_status_type       queue_status,
   output logic                            queue_push,
   output rer_pkg::run_rec_type            queue_data
);

   logic [rer_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic                        open_ff, open_in;
   logic [rer_pkg::POS_W-1:0]   start_ff, start_in;
   logic [rer_pkg::POS_W-1:0]   last_ff, last_in;
   logic [rer_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic [rer_pkg::COUNT_W-1:0] count_ff, count_in;

   logic                        accept;
   logic [rer_pkg::PIX_W-1:0]   grad;
   logic                        is_strong;
   logic [rer_pkg::POS_W-1:0]   gap_dist;
   logic                        gap_close;
   logic                        close;
   logic                        len_ok;
   logic [rer_pkg::LEN_W-1:0]   run_len;
   logic [rer_pkg::TOTAL_W:0]   total_sum;
   logic                        open_upd;
   logic [rer_pkg::POS_W-1:0]   start_upd;
   logic [rer_pkg::POS_W-1:0]   last_upd;
   logic [rer_pkg::TOTAL_W-1:0] total_upd;
   logic [rer_pkg::COUNT_W-1:0] count_upd;

   assign req_stall = queue_status.full;
   assign accept    = req_valid && !queue_status.full;

   always_comb begin
      grad = (req_after_pixel >= req_before_pixel) ? req_after_pixel - req_before_pixel
                                                   : req_before_pixel - req_after_pixel;
      is_strong = grad >= cfg.threshold;
      gap_dist  = pos_ff - last_ff;
      gap_close = !is_strong && open_ff && (pos_ff >= last_ff) && (gap_dist > cfg.max_gap);
      total_sum = {1'b0, total_ff} + (rer_pkg::TOTAL_W + 1)'(grad);

      open_upd  = open_ff;
      start_upd = start_ff;
      last_upd  = last_ff;
      total_upd = total_ff;
      count_upd = count_ff;
      if (is_strong) begin
         open_upd = 1'b1;
         last_upd = pos_ff;
         if (!open_ff) begin
            start_upd = pos_ff;
            total_upd = rer_pkg::TOTAL_W'(grad);
            count_upd = rer_pkg::COUNT_W'(1);
         end else begin
            total_upd = total_sum[rer_pkg::TOTAL_W] ? rer_pkg::TOTAL_MAX
                                                    : total_sum[rer_pkg::TOTAL_W-1:0];
            count_upd = (count_ff == rer_pkg::COUNT_MAX) ? count_ff
                                                         : count_ff + 1'b1;
         end
      end

      // A gap close clears the run, so the end of the line finds nothing open.
      close   = gap_close || (req_end_of_line && open_upd);
      run_len = rer_pkg::LEN_W'(last_upd) - rer_pkg::LEN_W'(start_upd) + 1'b1;
      len_ok  = (last_upd >= start_upd) && (run_len >= cfg.min_length);

      queue_push       = accept && close && len_ok;
      queue_data.line  = req_line_index;
      queue_data.first = start_upd;
      queue_data.last  = last_upd;
      queue_data.total = total_upd;
      queue_data.count = count_upd;

      pos_in   = pos_ff;
      open_in  = open_ff;
      start_in = start_ff;
      last_in  = last_ff;
      total_in = total_ff;
      count_in = count_ff;
      if (accept) begin
         if (close || req_end_of_line) begin
            open_in  = 1'b0;
            start_in = '0;
            last_in  = '0;
            total_in = '0;
            count_in = '0;
         end else begin
            open_in  = open_upd;
            start_in = start_upd;
            last_in  = last_upd;
            total_in = total_upd;
            count_in = count_upd;
         end
         if (req_end_of_line) begin
            pos_in = '0;
         end else if (pos_ff < rer_pkg::POS_MAX) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         open_ff  <= 1'b0;
         start_ff <= '0;
         last_ff  <= '0;
         total_ff <= '0;
         count_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         open_ff  <= open_in;
         start_ff <= start_in;
         last_ff  <= last_in;
         total_ff <= total_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== design/rer_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run queue
// Small first-in first-out buffer of closed runs between the run tracker and
// the strength unit.
// ----------------------------------------------------------------------------
module rer_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  rer_pkg::queue_ctl_type       ctl,
   input  rer_pkg::run_rec_type         push_data,
   output rer_pkg::run_rec_type         pop_data,
   output rer_pkg::queue_status_type    status
);

   rer_pkg::run_rec_type               entry_ff [rer_pkg::QUEUE_DEPTH];
   logic [rer_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [rer_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [rer_pkg::QUEUE_CNT_W-1:0]    fill_ff, fill_in;
   logic                               do_push;
   logic                               do_pop;

   always_comb begin
      status.full  = fill_ff == rer_pkg::QUEUE_CNT_W'(rer_pkg::QUEUE_DEPTH);
      status.empty = fill_ff == '0;
      do_push      = ctl.push && !status.full;
      do_pop       = ctl.pop && !status.empty;
      pop_data     = entry_ff[rd_ptr_ff];
      wr_ptr_in    = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in    = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in      = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ===== design/rer_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strength unit
// Takes closed runs from the queue, works out the saturated mean gradient
// with a bit-serial divider and holds the result in the output register.
// ----------------------------------------------------------------------------
module rer_back (
   input  logic                               clock,
   input  logic                               reset,
   input  rer_pkg::queue_status_type          queue_status,
   input  rer_pkg::run_rec_type               queue_data,
   output logic                               queue_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [rer_pkg::LINE_W-1:0]         rsp_run_line,
   output logic [rer_pkg::POS_W-1:0]          rsp_run_first,
   output logic [rer_pkg::POS_W-1:0]          rsp_run_last,
   output logic [rer_pkg::STRENGTH_W-1:0]     rsp_run_strength
);

   rer_pkg::back_state_type               state_ff, state_in;
   rer_pkg::run_rec_type                  rec_ff, rec_in;
   logic [rer_pkg::DIVISOR_W-1:0]         divisor_ff, divisor_in;
   logic [rer_pkg::TOTAL_W-1:0]           rem_ff, rem_in;
   logic [rer_pkg::STRENGTH_W-1:0]        quot_ff, quot_in;
   logic [rer_pkg::STEP_W-1:0]            step_ff, step_in;
   logic                                  out_valid_ff, out_valid_in;
   logic [rer_pkg::LINE_W-1:0]            out_line_ff, out_line_in;
   logic [rer_pkg::POS_W-1:0]             out_first_ff, out_first_in;
   logic [rer_pkg::POS_W-1:0]             out_last_ff, out_last_in;
   logic [rer_pkg::STRENGTH_W-1:0]        out_strength_ff, out_strength_in;

   logic [rer_pkg::COUNT_W-1:0]           count_eff;
   logic [rer_pkg::TOTAL_W:0]             rem_shift;
   logic                                  quot_bit;
   logic                                  out_free;
   logic                                  load_out;

   assign rsp_valid        = out_valid_ff;
   assign rsp_run_line     = out_line_ff;
   assign rsp_run_first    = out_first_ff;
   assign rsp_run_last     = out_last_ff;
   assign rsp_run_strength = out_strength_ff;

   always_comb begin
      state_in   = state_ff;
      rec_in     = rec_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      step_in    = step_ff;
      queue_pop  = 1'b0;
      load_out   = 1'b0;
      out_free   = !out_valid_ff || !rsp_stall;
      count_eff  = (rec_ff.count == '0) ? rer_pkg::COUNT_W'(1) : rec_ff.count;
      rem_shift  = {rem_ff, 1'b0};
      quot_bit   = rem_shift >= (rer_pkg::TOTAL_W + 1)'(divisor_ff);

      unique case (state_ff)
         rer_pkg::ST_IDLE: begin
            if (!queue_status.empty) begin
               queue_pop = 1'b1;
               rec_in    = queue_data;
               state_in  = rer_pkg::ST_SCALE;
            end
         end
         rer_pkg::ST_SCALE: begin
            divisor_in = rer_pkg::DIVISOR_W'(count_eff) *
                         rer_pkg::DIVISOR_W'(rer_pkg::GRAD_SCALE);
            state_in   = rer_pkg::ST_CHECK;
         end
         rer_pkg::ST_CHECK: begin
            // total >= 90*count means the mean is 1.0 or more, which saturates.
            if (rer_pkg::DIVISOR_W'(rec_ff.total) >= divisor_ff) begin
               quot_in  = rer_pkg::STRENGTH_FULL;
               state_in = rer_pkg::ST_EMIT;
            end else begin
               rem_in   = rec_ff.total;
               quot_in  = '0;
               step_in  = '0;
               state_in = rer_pkg::ST_DIVIDE;
            end
         end
         rer_pkg::ST_DIVIDE: begin
            // The remainder stays below the divisor, so eight steps yield
            // floor(256 * total / divisor).
            rem_in  = quot_bit ? rer_pkg::TOTAL_W'(rem_shift - (rer_pkg::TOTAL_W + 1)'(divisor_ff))
                               : rem_shift[rer_pkg::TOTAL_W-1:0];
            quot_in = {quot_ff[rer_pkg::STRENGTH_W-2:0], quot_bit};
            step_in = step_ff + 1'b1;
            if (step_ff == rer_pkg::STEP_W'(rer_pkg::DIV_STEPS - 1)) begin
               state_in = rer_pkg::ST_EMIT;
            end
         end
         rer_pkg::ST_EMIT: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = rer_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rer_pkg::ST_IDLE;
         end
      endcase

      out_valid_in    = load_out ? 1'b1 : (out_valid_ff && rsp_stall);
      out_line_in     = load_out ? rec_ff.line  : out_line_ff;
      out_first_in    = load_out ? rec_ff.first : out_first_ff;
      out_last_in     = load_out ? rec_ff.last  : out_last_ff;
      out_strength_in = load_out ? quot_ff      : out_strength_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rer_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff          <= rec_in;
      divisor_ff      <= divisor_in;
      rem_ff          <= rem_in;
      quot_ff         <= quot_in;
      out_line_ff     <= out_line_in;
      out_first_ff    <= out_first_in;
      out_last_ff     <= out_last_in;
      out_strength_ff <= out_strength_in;
   end

endmodule

// ===== design/gradient_edge_run_extractor_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient edge run extractor
// Finds runs of strong vertical gradient along each scan line and reports
// each long enough run with its line, first and last position and strength.
// ----------------------------------------------------------------------------
// Throughput: one pixel pair per cycle while the four-entry run queue has room.
// Each reported run takes the strength unit through pop, scale, check, 8 divide
// steps and emit; the divide steps are skipped when the strength saturates.
// Result path: the closing run enters the queue, the strength unit pops it when
// idle, and emit loads the output register that raises rsp_valid once it is free.
// Reset (synchronous): configuration returns to its defaults, the line position
// and run state clear, the queue empties and no result is held.
module gradient_edge_run_extractor_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [rer_pkg::PIX_W-1:0]          req_before_pixel,
   input  logic [rer_pkg::PIX_W-1:0]          req_after_pixel,
   input  logic [rer_pkg::LINE_W-1:0]         req_line_index,
   input  logic                               req_end_of_line,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [rer_pkg::LINE_W-1:0]         rsp_run_line,
   output logic [rer_pkg::POS_W-1:0]          rsp_run_first,
   output logic [rer_pkg::POS_W-1:0]          rsp_run_last,
   output logic [rer_pkg::STRENGTH_W-1:0]     rsp_run_strength,
   input  logic                               csr_write,
   input  logic [rer_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rer_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   rer_pkg::cfg_type              cfg_ff, cfg_in;
   rer_pkg::queue_ctl_type        queue_ctl;
   rer_pkg::queue_status_type     queue_status;
   rer_pkg::run_rec_type          push_data;
   rer_pkg::run_rec_type          pop_data;
   logic                          queue_push;
   logic                          queue_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            rer_pkg::CSR_THRESHOLD:  cfg_in.threshold  = csr_wdata[rer_pkg::PIX_W-1:0];
            rer_pkg::CSR_MIN_LENGTH: cfg_in.min_length = csr_wdata[rer_pkg::LEN_W-1:0];
            rer_pkg::CSR_MAX_GAP:    cfg_in.max_gap    = csr_wdata[rer_pkg::GAP_W-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold  <= rer_pkg::RESET_THRESHOLD;
         cfg_ff.min_length <= rer_pkg::RESET_MIN_LENGTH;
         cfg_ff.max_gap    <= rer_pkg::RESET_MAX_GAP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign queue_ctl.push = queue_push;
   assign queue_ctl.pop  = queue_pop;

   rer_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_before_pixel (req_before_pixel),
      .req_after_pixel  (req_after_pixel),
      .req_line_index   (req_line_index),
      .req_end_of_line  (req_end_of_line),
      .queue_status     (queue_status),
      .queue_push       (queue_push),
      .queue_data       (push_data)
   );

   rer_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctl       (queue_ctl),
      .push_data (push_data),
      .pop_data  (pop_data),
      .status    (queue_status)
   );

   rer_back u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_status     (queue_status),
      .queue_data       (pop_data),
      .queue_pop        (queue_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_run_line     (rsp_run_line),
      .rsp_run_first    (rsp_run_first),
      .rsp_run_last     (rsp_run_last),
      .rsp_run_strength (rsp_run_strength)
   );

endmodule

// ===== design/rer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port checker
// Watches the top level ports for result-channel rules and result ranges.
// ----------------------------------------------------------------------------
module rer_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [rer_pkg::LINE_W-1:0]         rsp_run_line,
   input  logic [rer_pkg::POS_W-1:0]          rsp_run_first,
   input  logic [rer_pkg::POS_W-1:0]          rsp_run_last,
   input  logic [rer_pkg::STRENGTH_W-1:0]     rsp_run_strength
);

   // A stalled transaction keeps its payload until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_run_line) &&
      $stable(rsp_run_first) && $stable(rsp_run_last) && $stable(rsp_run_strength))
      else $error("result changed while stalled");

   // No result is held right after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // Strength saturates at 1.0.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_run_strength <= rer_pkg::STRENGTH_FULL)
      else $error("strength above full scale");

   // A run never ends before it begins.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_run_first <= rsp_run_last)
      else $error("run ends before its first pixel");

endmodule

bind gradient_edge_run_extractor_core rer_checker u_rer_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_run_line     (rsp_run_line),
   .rsp_run_first    (rsp_run_first),
   .rsp_run_last     (rsp_run_last),
   .rsp_run_strength (rsp_run_strength)
);
